// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms sample on the rising
// clock edge and are disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/imhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imhq_pkg;

  // Sizes of the heap and of the tag table.
  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned TAG_COUNT = 1024;
  localparam int unsigned KEY_BITS = 32;

  // Field widths at the ports.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 10;

  // Derived index widths.
  localparam int unsigned POS_BITS = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_BITS = POS_BITS + 2;
  localparam int unsigned TAG_ADDR_BITS = $clog2(TAG_COUNT);
  localparam int unsigned INIT_BITS = TAG_ADDR_BITS + 1;

  // One heap slot.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_POP      = 3'd1,
    CMD_DECREASE = 3'd2,
    CMD_INCREASE = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOTAG = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/core/imhq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_min_heap_queue.sv =====
// Indexed binary min-heap queue of (key, tag) entries.
// Input channel (in_valid_i/in_ready_o) carries one command per transfer:
// insert, pop minimum, decrease key, increase key or clear. Output channel
// (out_valid_o/out_ready_i) returns one result per command: the popped tag
// and key, a status code and the entry count after the command.
// The heap lives in one RAM of key and tag, and a second RAM maps each tag
// to its heap position. A tag counts as queued when its stored position is
// below the count and the heap slot there holds the same tag.
// Steps: a tag lookup reads the position table and then the heap slot; each
// sift-up level reads the parent, then compares and writes; each sift-down
// level reads both children on one read port, then compares and writes;
// a final write and the result follow. Pop on an empty queue and clear go
// straight to the result. The read-compare-write loop through the heap RAM
// sets the pace of a command. One command is in work at a time.
// After reset a sweep over all TAG_COUNT entries (1024) zeroes the position
// table, and no command is taken during it. A finished result sits in an output
// register; while the receiver stalls the next command is taken and worked
// on, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module indexed_min_heap_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [2:0]                    command_i,
  input  wire logic [imhq_pkg::KEY_W-1:0]    key_value_i,
  input  wire logic [imhq_pkg::TAG_W-1:0]    entry_tag_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [imhq_pkg::TAG_W-1:0]    out_tag_o,
  output      logic [imhq_pkg::KEY_W-1:0]    out_key_o,
  output      logic [1:0]                    status_o,
  output      logic [10:0]                   entry_count_o
);

  localparam int unsigned PB = imhq_pkg::POS_BITS;
  localparam int unsigned CB = imhq_pkg::CNT_BITS;
  localparam int unsigned HB = imhq_pkg::CHILD_BITS;
  localparam int unsigned TA = imhq_pkg::TAG_ADDR_BITS;
  localparam int unsigned KB = imhq_pkg::KEY_BITS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TAGRD, S_HEAPRD, S_CHECK, S_POPRD, S_POPLAST, S_POPSET,
    S_UPRD, S_UPCMP, S_DNRDL, S_DNRDR, S_DNCMP, S_FINAL, S_DONE
  } state_e;

  state_e                      state_q;
  logic [imhq_pkg::INIT_BITS-1:0] init_cnt_q;
  logic [2:0]                  cmd_q;
  logic [KB-1:0]               key_q;
  logic [imhq_pkg::TAG_W-1:0]  tag_q;
  logic [CB-1:0]               count_q;
  logic [PB-1:0]               pos_q;
  imhq_pkg::entry_t            held_q;
  imhq_pkg::entry_t            left_q;
  logic                        down_after_q;
  logic                        rvalid_q;
  imhq_pkg::status_e           res_status_q;
  logic [imhq_pkg::TAG_W-1:0]  res_tag_q;
  logic [KB-1:0]               res_key_q;
  logic                        out_valid_q;
  logic [imhq_pkg::TAG_W-1:0]  out_tag_q;
  logic [imhq_pkg::KEY_W-1:0]  out_key_q;
  logic [1:0]                  status_q;
  logic [CB-1:0]               out_count_q;

  // RAM ports.
  logic                        heap_we;
  logic [PB-1:0]               heap_waddr;
  imhq_pkg::entry_t            heap_wdata;
  logic [PB-1:0]               heap_raddr;
  imhq_pkg::entry_t            heap_rdata;
  logic                        tag_we;
  logic [TA-1:0]               tag_waddr;
  logic [PB-1:0]               tag_wdata;
  logic [TA-1:0]               tag_raddr;
  logic [PB-1:0]               tag_rdata;

  // Index arithmetic on the hole position.
  logic [PB-1:0]               parent;
  logic [HB-1:0]               lchild;
  logic [HB-1:0]               rchild;
  logic [CB-1:0]               count_m1;
  logic                        found;
  logic                        tag_ok;
  logic                        move_l;
  logic                        move_r;
  logic [KB-1:0]               best_key;
  imhq_pkg::entry_t            best_entry;
  logic [PB-1:0]               best_pos;
  logic                        up_move;

  assign parent   = (pos_q - PB'(1)) >> 1;
  assign lchild   = {1'b0, pos_q, 1'b1};
  assign rchild   = lchild + HB'(1);
  assign count_m1 = count_q - CB'(1);
  assign tag_ok   = 32'(tag_q) < 32'(imhq_pkg::TAG_COUNT);
  assign found    = (CB'(pos_q) < count_q) && (heap_rdata.tag == tag_q);
  assign up_move  = heap_rdata.key > held_q.key;

  // Child selection: left wins ties, a child moves only if strictly smaller.
  assign move_l     = left_q.key < held_q.key;
  assign best_key   = move_l ? left_q.key : held_q.key;
  assign move_r     = rvalid_q && (heap_rdata.key < best_key);
  assign best_entry = move_r ? heap_rdata : left_q;
  assign best_pos   = move_r ? rchild[PB-1:0] : lchild[PB-1:0];

  imhq_ram #(
    .WIDTH(imhq_pkg::ENTRY_W),
    .DEPTH(imhq_pkg::HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (heap_we),
    .waddr_i(heap_waddr),
    .wdata_i(heap_wdata),
    .raddr_i(heap_raddr),
    .rdata_o(heap_rdata)
  );

  imhq_ram #(
    .WIDTH(PB),
    .DEPTH(imhq_pkg::TAG_COUNT)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(tag_wdata),
    .raddr_i(tag_raddr),
    .rdata_o(tag_rdata)
  );

  // Memory port control for each step of the sequencer.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = held_q;
    heap_raddr = '0;
    tag_we     = 1'b0;
    tag_waddr  = held_q.tag[TA-1:0];
    tag_wdata  = pos_q;
    tag_raddr  = tag_q[TA-1:0];
    case (state_q)
      S_INIT: begin
        tag_we    = 1'b1;
        tag_waddr = init_cnt_q[TA-1:0];
        tag_wdata = '0;
      end
      S_HEAPRD:  heap_raddr = tag_rdata;
      S_POPLAST: heap_raddr = count_m1[PB-1:0];
      S_UPRD:    heap_raddr = parent;
      S_UPCMP: begin
        if (up_move) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          tag_we     = 1'b1;
          tag_waddr  = heap_rdata.tag[TA-1:0];
        end
      end
      S_DNRDL: heap_raddr = lchild[PB-1:0];
      S_DNRDR: heap_raddr = rchild[PB-1:0];
      S_DNCMP: begin
        if (move_l || move_r) begin
          heap_we    = 1'b1;
          heap_wdata = best_entry;
          tag_we     = 1'b1;
          tag_waddr  = best_entry.tag[TA-1:0];
        end
      end
      S_FINAL: begin
        heap_we = 1'b1;
        tag_we  = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_tag_o     = out_tag_q;
  assign out_key_o     = out_key_q;
  assign status_o      = status_q;
  assign entry_count_o = 11'(out_count_q);

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_cnt_q   <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      down_after_q <= 1'b0;
      rvalid_q     <= 1'b0;
      res_status_q <= imhq_pkg::ST_OK;
    end else begin
      // The output register drains unless a new result is loaded below.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          init_cnt_q <= init_cnt_q + imhq_pkg::INIT_BITS'(1);
          if (init_cnt_q == imhq_pkg::INIT_BITS'(imhq_pkg::TAG_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= command_i;
            key_q        <= key_value_i[KB-1:0];
            tag_q        <= entry_tag_i;
            res_status_q <= imhq_pkg::ST_OK;
            res_tag_q    <= '0;
            res_key_q    <= '0;
            case (command_i)
              imhq_pkg::CMD_INSERT, imhq_pkg::CMD_DECREASE,
              imhq_pkg::CMD_INCREASE: state_q <= S_TAGRD;
              imhq_pkg::CMD_POP: begin
                if (count_q == '0) begin
                  res_status_q <= imhq_pkg::ST_EMPTY;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_POPRD;
                end
              end
              imhq_pkg::CMD_CLEAR: begin
                count_q <= '0;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_TAGRD: begin
          if (!tag_ok) begin
            res_status_q <= imhq_pkg::ST_NOTAG;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_HEAPRD;
          end
        end
        S_HEAPRD: begin
          pos_q   <= tag_rdata;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          held_q.key <= key_q;
          held_q.tag <= tag_q;
          case (cmd_q)
            imhq_pkg::CMD_INSERT: begin
              if (found) begin
                down_after_q <= 1'b1;
                state_q      <= S_UPRD;
              end else if (count_q == CB'(imhq_pkg::HEAP_DEPTH)) begin
                res_status_q <= imhq_pkg::ST_FULL;
                state_q      <= S_DONE;
              end else begin
                pos_q        <= count_q[PB-1:0];
                count_q      <= count_q + CB'(1);
                down_after_q <= 1'b0;
                state_q      <= S_UPRD;
              end
            end
            imhq_pkg::CMD_DECREASE: begin
              if (!found) begin
                res_status_q <= imhq_pkg::ST_NOTAG;
                state_q      <= S_DONE;
              end else if (key_q < heap_rdata.key) begin
                down_after_q <= 1'b0;
                state_q      <= S_UPRD;
              end else begin
                state_q <= S_DONE;
              end
            end
            default: begin
              if (!found) begin
                res_status_q <= imhq_pkg::ST_NOTAG;
                state_q      <= S_DONE;
              end else if (key_q > heap_rdata.key) begin
                state_q <= S_DNRDL;
              end else begin
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_POPRD: state_q <= S_POPLAST;
        S_POPLAST: begin
          res_tag_q <= heap_rdata.tag;
          res_key_q <= heap_rdata.key;
          state_q   <= S_POPSET;
        end
        S_POPSET: begin
          held_q  <= heap_rdata;
          pos_q   <= '0;
          count_q <= count_m1;
          state_q <= S_DNRDL;
        end
        S_UPRD: begin
          if (pos_q == '0) begin
            state_q <= down_after_q ? S_DNRDL : S_FINAL;
          end else begin
            state_q <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (up_move) begin
            pos_q   <= parent;
            state_q <= S_UPRD;
          end else begin
            state_q <= down_after_q ? S_DNRDL : S_FINAL;
          end
        end
        S_DNRDL: begin
          if (lchild >= HB'(count_q)) begin
            state_q <= S_FINAL;
          end else begin
            state_q <= S_DNRDR;
          end
        end
        S_DNRDR: begin
          left_q   <= heap_rdata;
          rvalid_q <= rchild < HB'(count_q);
          state_q  <= S_DNCMP;
        end
        S_DNCMP: begin
          if (move_l || move_r) begin
            pos_q   <= best_pos;
            state_q <= S_DNRDL;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_tag_q   <= res_tag_q;
            out_key_q   <= imhq_pkg::KEY_W'(res_key_q);
            status_q    <= res_status_q;
            out_count_q <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The entry count never exceeds the heap depth.
  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CB'(imhq_pkg::HEAP_DEPTH))
  // Entries moved during a sift stay inside the occupied part of the heap.
  `ASSERT_IMPL(a_move_in_heap, clk_i, rst_ni, heap_we && (state_q != S_FINAL),
               CB'(heap_waddr) < count_q)
  // A move during sift-down takes the hole to a deeper slot.
  `ASSERT_NEXT(a_down_deeper, clk_i, rst_ni, (state_q == S_DNCMP) && heap_we,
               pos_q > $past(pos_q))
  // A move during sift-up takes the hole toward the root.
  `ASSERT_NEXT(a_up_shallower, clk_i, rst_ni, (state_q == S_UPCMP) && heap_we,
               pos_q < $past(pos_q))
  // A result is only loaded when the output register is free or draining.
  `ASSERT_NEXT(a_no_overwrite, clk_i, rst_ni,
               out_valid_q && !out_ready_i && (state_q == S_DONE),
               out_valid_q && (state_q == S_DONE))

endmodule

`default_nettype wire

// ===== bench/heap_checker.sv =====
`timescale 1ns / 1ps

module heap_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] key_value_i,
  input  logic [9:0]  entry_tag_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [9:0]  out_tag_i,
  input  logic [31:0] out_key_i,
  input  logic [1:0]  status_i,
  input  logic [10:0] entry_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [9:0]  tag;
    logic [31:0] key;
    logic [1:0]  status;
    logic [10:0] count;
  } answer_t;

  // Shadow heap with its own tag position table.
  logic [31:0] slot_key [imhq_pkg::HEAP_DEPTH];
  logic [9:0]  slot_tag [imhq_pkg::HEAP_DEPTH];
  int          tag_slot [imhq_pkg::TAG_COUNT];
  bit          tag_held [imhq_pkg::TAG_COUNT];
  int          held = 0;
  int          fails = 0;
  int          due = 0;
  answer_t     answers_due[$];

  assign fail_count_o = fails;
  assign pending_o = due;

  function automatic void swap_slots(int a, int b);
    logic [31:0] k;
    logic [9:0]  t;
    k = slot_key[a]; t = slot_tag[a];
    slot_key[a] = slot_key[b]; slot_tag[a] = slot_tag[b];
    slot_key[b] = k; slot_tag[b] = t;
    tag_slot[slot_tag[a]] = a;
    tag_slot[slot_tag[b]] = b;
  endfunction

  function automatic void bubble_up(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (!(slot_key[up] > slot_key[p])) break;
      swap_slots(up, p);
      p = up;
    end
  endfunction

  function automatic void push_down(int p);
    int best;
    int lc;
    forever begin
      best = p;
      lc = 2 * p + 1;
      if (lc < held && slot_key[lc] < slot_key[best]) best = lc;
      if (lc + 1 < held && slot_key[lc + 1] < slot_key[best]) best = lc + 1;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  // Apply one command to the shadow heap and return its expected answer.
  function automatic answer_t apply_command(logic [2:0] cmd, logic [31:0] key, logic [9:0] tag);
    answer_t a;
    int p;
    a = '0;
    a.status = imhq_pkg::ST_OK;
    case (cmd)
      imhq_pkg::CMD_INSERT: begin
        if (tag_held[tag]) begin
          p = tag_slot[tag];
          slot_key[p] = key;
          bubble_up(p);
          push_down(tag_slot[tag]);
        end else if (held >= imhq_pkg::HEAP_DEPTH) begin
          a.status = imhq_pkg::ST_FULL;
        end else begin
          slot_key[held] = key;
          slot_tag[held] = tag;
          tag_slot[tag] = held;
          tag_held[tag] = 1'b1;
          held++;
          bubble_up(held - 1);
        end
      end
      imhq_pkg::CMD_POP: begin
        if (held == 0) begin
          a.status = imhq_pkg::ST_EMPTY;
        end else begin
          a.tag = slot_tag[0];
          a.key = slot_key[0];
          swap_slots(0, held - 1);
          tag_held[slot_tag[held - 1]] = 1'b0;
          held--;
          push_down(0);
        end
      end
      imhq_pkg::CMD_DECREASE, imhq_pkg::CMD_INCREASE: begin
        if (!tag_held[tag]) begin
          a.status = imhq_pkg::ST_NOTAG;
        end else begin
          p = tag_slot[tag];
          if (cmd == imhq_pkg::CMD_DECREASE && key < slot_key[p]) begin
            slot_key[p] = key;
            bubble_up(p);
          end else if (cmd == imhq_pkg::CMD_INCREASE && key > slot_key[p]) begin
            slot_key[p] = key;
            push_down(p);
          end
        end
      end
      imhq_pkg::CMD_CLEAR: begin
        held = 0;
        foreach (tag_held[i]) tag_held[i] = 1'b0;
      end
      default: ;
    endcase
    a.count = held[10:0];
    return a;
  endfunction

  // Predict on every input transfer and compare on every output transfer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with nothing expected: tag %0d key %h status %0d count %0d",
                   $time, out_tag_i, out_key_i, status_i, entry_count_i);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (want != {out_tag_i, out_key_i, status_i, entry_count_i}) begin
            $display("%0t: expected tag %0d key %h status %0d count %0d,",
                     $time, want.tag, want.key, want.status, want.count);
            $display("%0t: got tag %0d key %h status %0d count %0d",
                     $time, out_tag_i, out_key_i, status_i, entry_count_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        answers_due.push_back(apply_command(command_i, key_value_i, entry_tag_i));
    end
    due = answers_due.size();
  end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [31:0] key_value_i = '0;
  logic [9:0]  entry_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  out_tag_o;
  logic [31:0] out_key_o;
  logic [1:0]  status_o;
  logic [10:0] entry_count_o;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  bit          hold_done = 1'b0;
  int          idle_cycles = 0;

  indexed_min_heap_queue u_dut (.*);

  heap_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .key_value_i,
    .entry_tag_i, .out_valid_i(out_valid_o), .out_ready_i, .out_tag_i(out_tag_o),
    .out_key_i(out_key_o), .status_i(status_o), .entry_count_i(entry_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Offer one command and hold it until the transfer, idling at random first.
  task automatic send_command(imhq_pkg::cmd_e cmd, logic [31:0] key, logic [9:0] tag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    key_value_i <= key;
    entry_tag_i <= tag;
    // Ready only changes at the rising edge, so it is stable here.
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Keys from a narrow range half the time, and often extremes, so that ties are common.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int pick;
    int tag_span;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty pop, unknown tags, extremes, ties, undefined commands, clear.
    send_command(imhq_pkg::CMD_POP, 32'h0, 10'h0);
    send_command(imhq_pkg::CMD_DECREASE, 32'h5, 10'h3);
    send_command(imhq_pkg::CMD_INCREASE, 32'h5, 10'h3FF);
    send_command(imhq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 10'h3FF);
    send_command(imhq_pkg::CMD_INSERT, 32'h0, 10'h0);
    send_command(imhq_pkg::CMD_INSERT, 32'h7, 10'h155);
    send_command(imhq_pkg::CMD_INSERT, 32'h7, 10'h2AA);
    send_command(imhq_pkg::CMD_INSERT, 32'h7, 10'h1);
    send_command(imhq_pkg::CMD_INSERT, 32'h3, 10'h155);
    send_command(imhq_pkg::CMD_DECREASE, 32'h9, 10'h2AA);
    send_command(imhq_pkg::CMD_DECREASE, 32'h1, 10'h2AA);
    send_command(imhq_pkg::CMD_INCREASE, 32'h2, 10'h0);
    send_command(imhq_pkg::CMD_INCREASE, 32'hFFFF_FFFE, 10'h0);
    send_command(imhq_pkg::CMD_POP, 32'h0, 10'h0);
    send_command(imhq_pkg::CMD_POP, 32'h0, 10'h0);
    send_command(imhq_pkg::cmd_e'(3'd5), 32'h1, 10'h1);
    send_command(imhq_pkg::cmd_e'(3'd7), 32'h1, 10'h1);
    send_command(imhq_pkg::CMD_CLEAR, 32'h0, 10'h0);
    send_command(imhq_pkg::CMD_INCREASE, 32'h9, 10'h1);
    send_command(imhq_pkg::CMD_POP, 32'h0, 10'h0);

    // Fill the heap to the top, insert once more on a queued tag, then pop and clear.
    for (int t = 0; t < imhq_pkg::TAG_COUNT; t++)
      send_command(imhq_pkg::CMD_INSERT, pick_key(), t[9:0]);
    send_command(imhq_pkg::CMD_INSERT, 32'h1, 10'h3FF);
    hold_off = 1'b1;
    for (int t = 0; t < 30; t++)
      send_command(imhq_pkg::CMD_POP, 32'h0, 10'h0);
    send_command(imhq_pkg::CMD_CLEAR, 32'h0, 10'h0);

    // Random part: mostly well-formed commands, first on a small tag set, then on all tags.
    for (int n = 0; n < 430; n++) begin
      if (n == 380) calm = 1'b1;
      tag_span = (n % 500 < 250) ? 15 : 1023;
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_command(imhq_pkg::CMD_INSERT, pick_key(), 10'($urandom_range(0, tag_span)));
      else if (pick < 65)
        send_command(imhq_pkg::CMD_POP, $urandom, 10'($urandom));
      else if (pick < 80)
        send_command(imhq_pkg::CMD_DECREASE, pick_key(), 10'($urandom_range(0, tag_span)));
      else if (pick < 95)
        send_command(imhq_pkg::CMD_INCREASE, pick_key(), 10'($urandom_range(0, tag_span)));
      else if (pick < 97)
        send_command(imhq_pkg::CMD_CLEAR, $urandom, 10'($urandom));
      else
        send_command(imhq_pkg::cmd_e'(3'($urandom_range(5, 7))), $urandom, 10'($urandom));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/imhq_pkg.sv
rtl/core/imhq_ram.sv
rtl/core/indexed_min_heap_queue.sv
bench/heap_checker.sv
bench/tb_top.sv
